### hw/rtl/fgrld_pkg.sv
// ----------------------------------------------------------------------------
// fgrld_pkg
// Shared types and constants of the glyph run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fgrld_pkg;

    localparam int FGRLD_DICT_ENTRIES = 31;
    localparam int FGRLD_QUEUE_DEPTH  = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int DICT_IDX_W  = 5;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DICT_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DICT_BASE = 3'd1;

    // Token classes
    localparam logic [7:0] TOK_DICT_LIMIT_M0 = 8'hF0;
    localparam logic [7:0] TOK_DICT_LIMIT_M1 = 8'hF8;
    localparam int         TOK_RAW_BIT       = 3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RAW,
        PH_REP
    } phase_t;

    // One expansion command: a byte and its copy count less one
    typedef struct packed {
        logic [7:0] value;
        logic [3:0] cnt_m1;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

endpackage

`default_nettype wire

### hw/rtl/fgrld_code_if.sv
// ----------------------------------------------------------------------------
// fgrld_code_if
// Compressed byte channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface fgrld_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       new_glyph;

    modport source (output valid, code_byte, new_glyph, input ready);
    modport sink   (input valid, code_byte, new_glyph, output ready);
endinterface

`default_nettype wire

### hw/rtl/fgrld_pixel_if.sv
// ----------------------------------------------------------------------------
// fgrld_pixel_if
// Decoded column byte channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface fgrld_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_column;
    logic       last_of_item;

    modport source (output valid, pixel_column, last_of_item, input ready);
    modport sink   (input valid, pixel_column, last_of_item, output ready);
endinterface

`default_nettype wire

### hw/rtl/fgrld_front.sv
// ----------------------------------------------------------------------------
// fgrld_front
// Accepts compressed bytes, tracks the token phase, looks up the
// dictionary and turns each byte into at most one expansion command.
// ----------------------------------------------------------------------------
`default_nettype none

module fgrld_front #(
    parameter int DICT_ENTRIES = fgrld_pkg::FGRLD_DICT_ENTRIES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [fgrld_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fgrld_pkg::CFG_DATA_W-1:0]  cfg_data,
    fgrld_code_if.sink                            code_ch,
    input  wire logic                             q_full,
    output fgrld_pkg::cmd_push_t                  push
);
    import fgrld_pkg::*;

    localparam int IDX_W = $clog2(DICT_ENTRIES);

    logic [7:0] dict_reg [DICT_ENTRIES];
    logic       dict_mode_reg;

    phase_t     phase_reg, phase_next;
    logic [3:0] run_reg, run_next;

    logic       accept;
    phase_t     phase_eff;
    logic [3:0] run_eff;
    logic [7:0] t;
    logic [DICT_IDX_W-1:0] dict_idx;
    logic [7:0] dict_val;

    assign code_ch.ready = !q_full;
    assign accept        = code_ch.valid && code_ch.ready;
    assign t             = code_ch.code_byte;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dict_mode_reg <= 1'b0;
        end
        else if (cfg_we && cfg_index == CFG_DICT_MODE)
        begin
            dict_mode_reg <= cfg_data[0];
        end
    end

    for (genvar k = 0; k < DICT_ENTRIES; k++)
    begin : g_dict
        localparam logic [CFG_INDEX_W-1:0] SLOT = CFG_DICT_BASE + CFG_INDEX_W'(k / 8);
        localparam int LANE = k % 8;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dict_reg[k] <= 8'h00;
            end
            else if (cfg_we && cfg_index == SLOT)
            begin
                dict_reg[k] <= cfg_data[LANE*8 +: 8];
            end
        end
    end

    // Dictionary read; entries beyond the table read as zero
    always_comb
    begin
        if (dict_mode_reg)
        begin
            dict_idx = t[7:3];
        end
        else
        begin
            dict_idx = {1'b0, t[7:4]};
        end
        if (dict_idx < DICT_IDX_W'(DICT_ENTRIES))
        begin
            dict_val = dict_reg[dict_idx[IDX_W-1:0]];
        end
        else
        begin
            dict_val = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            run_reg   <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            run_reg   <= run_next;
        end
    end

    always_comb
    begin
        phase_eff  = code_ch.new_glyph ? PH_IDLE : phase_reg;
        run_eff    = code_ch.new_glyph ? 4'd0 : run_reg;
        phase_next = phase_reg;
        run_next   = run_reg;
        push       = '0;

        if (accept)
        begin
            case (phase_eff)
                PH_RAW:
                begin
                    push.valid      = 1'b1;
                    push.cmd.value  = t;
                    push.cmd.cnt_m1 = 4'd0;
                    if (run_eff > 4'd1)
                    begin
                        phase_next = PH_RAW;
                        run_next   = run_eff - 4'd1;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        run_next   = 4'd0;
                    end
                end
                PH_REP:
                begin
                    push.valid      = 1'b1;
                    push.cmd.value  = t;
                    push.cmd.cnt_m1 = (run_eff == 4'd0) ? 4'd0 : run_eff - 4'd1;
                    phase_next      = PH_IDLE;
                    run_next        = 4'd0;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    run_next   = 4'd0;
                    if (!dict_mode_reg)
                    begin
                        if (t < TOK_DICT_LIMIT_M0)
                        begin
                            push.valid      = 1'b1;
                            push.cmd.value  = dict_val;
                            push.cmd.cnt_m1 = t[3:0];
                        end
                        else if (t[TOK_RAW_BIT])
                        begin
                            phase_next = PH_RAW;
                            run_next   = {1'b0, t[2:0]} + 4'd1;
                        end
                        else
                        begin
                            phase_next = PH_REP;
                            run_next   = {1'b0, t[2:0]} + 4'd2;
                        end
                    end
                    else
                    begin
                        if (t < TOK_DICT_LIMIT_M1)
                        begin
                            push.valid      = 1'b1;
                            push.cmd.value  = dict_val;
                            push.cmd.cnt_m1 = {1'b0, t[2:0]};
                        end
                        else
                        begin
                            phase_next = PH_RAW;
                            run_next   = {1'b0, t[2:0]} + 4'd1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fgrld_queue.sv
// ----------------------------------------------------------------------------
// fgrld_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fgrld_queue #(
    parameter int DEPTH = fgrld_pkg::FGRLD_QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fgrld_pkg::cmd_push_t push,
    input  wire logic                 pop,
    output logic                      q_valid,
    output fgrld_pkg::cmd_t           q_cmd,
    output logic                      q_full
);
    import fgrld_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push.valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (!q_full || pop))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### hw/rtl/fgrld_back.sv
// ----------------------------------------------------------------------------
// fgrld_back
// Expands queued commands into column bytes, one per cycle while the receiver
// is ready and a command is queued, from a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fgrld_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire fgrld_pkg::cmd_t q_cmd,
    output logic                 pop,
    fgrld_pixel_if.source        pixel_ch
);
    import fgrld_pkg::*;

    logic       active_reg, active_next;
    logic [3:0] left_reg, left_next;
    logic [7:0] val_reg, val_next;
    logic       take;

    assign take                  = pixel_ch.valid && pixel_ch.ready;
    assign pixel_ch.valid        = active_reg;
    assign pixel_ch.pixel_column = val_reg;
    assign pixel_ch.last_of_item = (left_reg == 4'd0);

    assign pop = q_valid && (!active_reg || (take && left_reg == 4'd0));

    always_comb
    begin
        active_next = active_reg;
        left_next   = left_reg;
        val_next    = val_reg;
        if (pop)
        begin
            active_next = 1'b1;
            left_next   = q_cmd.cnt_m1;
            val_next    = q_cmd.value;
        end
        else if (take)
        begin
            if (left_reg == 4'd0)
            begin
                active_next = 1'b0;
            end
            else
            begin
                left_next = left_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            left_reg   <= 4'd0;
        end
        else
        begin
            active_reg <= active_next;
            left_reg   <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    a_run_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && left_reg != 4'd0) |=> active_reg)
        else $error("run dropped before its last byte");

    a_run_value: assert property (@(posedge clk) disable iff (!rst_n)
        (take && left_reg != 4'd0) |=> (val_reg == $past(val_reg)))
        else $error("byte changed inside a run");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_ch.valid && !pixel_ch.ready) |=>
            (pixel_ch.valid && $stable(pixel_ch.pixel_column) &&
             $stable(pixel_ch.last_of_item)))
        else $error("column changed while stalled");

endmodule

`default_nettype wire

### hw/rtl/font_glyph_run_length_decoder_unit.sv
// Path: an accepted byte's command is queued, then loaded into the output register.
// Throughput in: one compressed byte per cycle while the command queue has room.
// Throughput out: one column per cycle while a command waits and the receiver is ready;
// a byte yields 0 to 16 columns, counted out by the expansion counter in the back end
// (none for a token opening a run); once the queue fills, input keeps pace with output.
// Reset: phase idle, run count zero, queue and output empty, mode and dictionary zero.
// ----------------------------------------------------------------------------
// font_glyph_run_length_decoder_unit
// Glyph column decompressor: run-length tokens with a frequent-byte dictionary.
// ----------------------------------------------------------------------------
`default_nettype none

module font_glyph_run_length_decoder_unit #(
    parameter int DICT_ENTRIES = fgrld_pkg::FGRLD_DICT_ENTRIES,
    parameter int QUEUE_DEPTH  = fgrld_pkg::FGRLD_QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [fgrld_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fgrld_pkg::CFG_DATA_W-1:0]  cfg_data,
    fgrld_code_if.sink                             code_ch,
    fgrld_pixel_if.source                          pixel_ch
);
    import fgrld_pkg::*;

    // Front to queue: at most one command per accepted byte
    cmd_push_t push;
    logic      q_full;

    // Queue to back
    logic      q_valid;
    cmd_t      q_cmd;
    logic      pop;

    // Front: hold the token phase, classify each byte, look up the dictionary.
    // Tokens that open a raw or repeat run give no command and only advance the phase.
    fgrld_front #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .code_ch   (code_ch),
        .q_full    (q_full),
        .push      (push)
    );

    // Queue: decouple input acceptance from output stalls
    fgrld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_full  (q_full)
    );

    // Back: repeat each command's byte its count of times; mark the final copy
    fgrld_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .pixel_ch (pixel_ch)
    );

endmodule

`default_nettype wire

### bench/tb_font_glyph_run_length_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_font_glyph_run_length_decoder_unit
// Self-checking bench for the glyph column run-length decoder. A short table
// of directed compressed bytes is walked first. Random phases follow, each
// under a fresh mode and dictionary. Every accepted byte is expanded by a
// local decoder model, and each column the block hands out is checked field
// by field against the oldest predicted column. The sender works in bursts
// and the column receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_font_glyph_run_length_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fgrld_pkg::*;

    // Register map: one index per register of the decoder
    localparam logic [CFG_INDEX_W-1:0] REG_DICT_MODE  = CFG_DICT_MODE;
    localparam logic [CFG_INDEX_W-1:0] REG_DICT_0_7   = CFG_DICT_BASE;
    localparam logic [CFG_INDEX_W-1:0] REG_DICT_8_15  = CFG_DICT_BASE + 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DICT_16_23 = CFG_DICT_BASE + 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DICT_24_30 = CFG_DICT_BASE + 3'd3;

    localparam logic [63:0] DICT_24_30_MASK = 64'h00FF_FFFF_FFFF_FFFF;

    // Drain time after the last predicted column, so a byte still in flight settles
    localparam int DRAIN_CYCLES   = 8;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 40;

    typedef struct packed {
        logic [7:0] pixel_column;
        logic       last_of_item;
    } column_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [63:0]            reg_value;
        logic [7:0]             code_byte;
        logic                   new_glyph;
        bit                     typed;
        logic [7:0]             typed_value;
        int                     typed_count;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    fgrld_code_if  code_ch ();
    fgrld_pixel_if pixel_ch ();

    font_glyph_run_length_decoder_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .code_ch  (code_ch),
        .pixel_ch (pixel_ch)
    );

    // Decoder model: its own copy of the registers and the run state
    logic        dict_mode_q;
    logic [63:0] dict_word [4];
    phase_t      glyph_phase;
    logic [3:0]  run_left;

    column_t     pending_columns [$];
    stim_row_t   directed_rows [$];
    column_t     oldest_column;

    int          error_count   = 0;
    int          byte_count    = 0;
    int          column_count  = 0;
    int          reg_writes    = 0;
    int          cycle_count   = 0;
    int          burst_left    = 0;
    bit          restart_glyph = 1'b0;

    int          stall_cycle   = 0;
    int          stall_style   = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Entries past the end of the dictionary read as zero
    function automatic logic [7:0] dict_entry(input logic [4:0] idx);
        logic [63:0] word;
        if (int'(idx) >= FGRLD_DICT_ENTRIES)
            return 8'h00;
        word = dict_word[idx[4:3]];
        return word[idx[2:0]*8 +: 8];
    endfunction

    // Queue the copies of one byte; only the final copy closes the item
    function automatic void add_columns(input logic [7:0] value, input int count,
                                        input bit keep);
        for (int k = 0; k < count; k++)
        begin
            if (keep)
                pending_columns.push_back('{pixel_column: value,
                                            last_of_item: (k == count - 1)});
        end
    endfunction

    function automatic void decode_code_byte(input logic [7:0] t, input logic ng,
                                             input bit keep);
        int cnt;
        if (ng)
        begin
            glyph_phase = PH_IDLE;
            run_left    = '0;
        end
        case (glyph_phase)
            PH_RAW:
            begin
                // A raw byte passes through once; the run ends on its last byte
                if (run_left > 4'd1)
                    run_left = run_left - 4'd1;
                else
                begin
                    run_left    = '0;
                    glyph_phase = PH_IDLE;
                end
                add_columns(t, 1, keep);
            end
            PH_REP:
            begin
                cnt         = (run_left != 0) ? int'(run_left) : 1;
                run_left    = '0;
                glyph_phase = PH_IDLE;
                add_columns(t, cnt, keep);
            end
            default:
            begin
                // Idle: the byte is a token, read by the mode in force now
                glyph_phase = PH_IDLE;
                run_left    = '0;
                if (!dict_mode_q)
                begin
                    if (t < TOK_DICT_LIMIT_M0)
                        add_columns(dict_entry({1'b0, t[7:4]}), int'(t[3:0]) + 1, keep);
                    else if (t[TOK_RAW_BIT])
                    begin
                        glyph_phase = PH_RAW;
                        run_left    = {1'b0, t[2:0]} + 4'd1;
                    end
                    else
                    begin
                        glyph_phase = PH_REP;
                        run_left    = {1'b0, t[2:0]} + 4'd2;
                    end
                end
                else if (t < TOK_DICT_LIMIT_M1)
                    add_columns(dict_entry(t[7:3]), int'(t[2:0]) + 1, keep);
                else
                begin
                    glyph_phase = PH_RAW;
                    run_left    = {1'b0, t[2:0]} + 4'd1;
                end
            end
        endcase
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [63:0] value);
        case (idx)
            REG_DICT_MODE:  dict_mode_q  = value[0];
            REG_DICT_0_7:   dict_word[0] = value;
            REG_DICT_8_15:  dict_word[1] = value;
            REG_DICT_16_23: dict_word[2] = value;
            REG_DICT_24_30: dict_word[3] = value & DICT_24_30_MASK;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void add_item_row(input logic [7:0] b, input logic ng,
                                         input bit typed, input logic [7:0] value,
                                         input int count);
        stim_row_t row;
        row = '{kind: ROW_ITEM, reg_index: '0, reg_value: '0, code_byte: b,
                new_glyph: ng, typed: typed, typed_value: value, typed_count: count};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [63:0] value);
        stim_row_t row;
        row = '{kind: ROW_REG, reg_index: idx, reg_value: value, code_byte: '0,
                new_glyph: 1'b0, typed: 1'b0, typed_value: '0, typed_count: 0};
        directed_rows.push_back(row);
    endfunction

    // Offer one compressed byte; bursts of random length, random gaps between.
    // Run the model on acceptance, in the same step.
    task automatic send_code(input logic [7:0] b, input logic ng, input bit keep);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 10);
        end
        code_ch.valid     <= 1'b1;
        code_ch.code_byte <= b;
        code_ch.new_glyph <= ng;
        @(posedge clk);
        while (!code_ch.ready)
            @(posedge clk);
        decode_code_byte(b, ng, keep);
        byte_count++;
        burst_left--;
        if (burst_left == 0)
            code_ch.valid <= 1'b0;
    endtask

    // Drop valid now unless the burst has already ended at this edge
    task automatic hold_code();
        if (burst_left != 0)
        begin
            code_ch.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    // Wait for every predicted column, then let a token still in flight settle
    task automatic wait_idle();
        hold_code();
        while (pending_columns.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        apply_reg(idx, value);
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed token sequences with random content; the rest is
    // noise and runs cut short by a new glyph
    task automatic run_random_phase(input int n_items);
        int         sent;
        int         choice;
        int         len;
        int         keep_len;
        logic [7:0] tok;
        logic       ng;
        sent = 0;
        while (sent < n_items)
        begin
            choice        = $urandom_range(0, 99);
            ng            = restart_glyph || ($urandom_range(0, 19) == 0);
            restart_glyph = 1'b0;
            if (choice < 10)
            begin
                send_code(8'($urandom), ng, 1'b1);
                sent++;
            end
            else if (choice < 45)
            begin
                if (dict_mode_q)
                    tok = 8'($urandom_range(0, int'(TOK_DICT_LIMIT_M1) - 1));
                else
                    tok = 8'($urandom_range(0, int'(TOK_DICT_LIMIT_M0) - 1));
                send_code(tok, ng, 1'b1);
                sent++;
            end
            else if (choice < 75 || dict_mode_q)
            begin
                // Raw run, now and then broken off early
                tok      = TOK_DICT_LIMIT_M1 | 8'($urandom_range(0, 7));
                len      = int'(tok[2:0]) + 1;
                keep_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
                send_code(tok, ng, 1'b1);
                sent++;
                for (int k = 0; k < keep_len; k++)
                begin
                    send_code(8'($urandom), 1'b0, 1'b1);
                    sent++;
                end
                if (keep_len < len)
                    restart_glyph = 1'b1;
            end
            else
            begin
                // Repeat token and its byte, or the byte withheld
                tok = TOK_DICT_LIMIT_M0 | 8'($urandom_range(0, 7));
                send_code(tok, ng, 1'b1);
                sent++;
                if ($urandom_range(0, 7) == 0)
                    restart_glyph = 1'b1;
                else
                begin
                    send_code(8'($urandom), 1'b0, 1'b1);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Column receiver: stall style redrawn at random from four styles
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        stall_cycle++;
        if (stall_cycle % 64 == 0)
            stall_style = $urandom_range(0, 3);
        case (stall_style)
            0: pixel_ch.ready <= 1'b1;
            1: pixel_ch.ready <= 1'($urandom_range(0, 1));
            2: pixel_ch.ready <= (stall_cycle % 4 != 0);
            default: pixel_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Column checker: compare each accepted column with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
        begin
            column_count++;
            if (pending_columns.size() == 0)
            begin
                $error("unexpected column %02h (last_of_item %0b) with none predicted",
                       pixel_ch.pixel_column, pixel_ch.last_of_item);
                error_count++;
            end
            else
            begin
                oldest_column = pending_columns.pop_front();
                if (pixel_ch.pixel_column !== oldest_column.pixel_column)
                begin
                    $error("pixel_column: expected %02h, got %02h",
                           oldest_column.pixel_column, pixel_ch.pixel_column);
                    error_count++;
                end
                if (pixel_ch.last_of_item !== oldest_column.last_of_item)
                begin
                    $error("last_of_item: expected %0b, got %0b",
                           oldest_column.last_of_item, pixel_ch.last_of_item);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a run that outlasts the limit is a hang
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d columns outstanding",
                 cycle_count, pending_columns.size());
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t   row;
        logic [63:0] word;
        logic [CFG_INDEX_W-1:0] dict_regs [4];

        dict_regs = '{REG_DICT_0_7, REG_DICT_8_15, REG_DICT_16_23, REG_DICT_24_30};

        // Drive every sender input to a known value from time zero; the
        // receiver sets its own ready from the first edge
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        code_ch.valid     <= 1'b0;
        code_ch.code_byte <= '0;
        code_ch.new_glyph <= 1'b0;

        // Model starts from the reset state
        dict_mode_q = 1'b0;
        for (int r = 0; r < 4; r++)
            dict_word[r] = '0;
        glyph_phase = PH_IDLE;
        run_left    = '0;

        // Directed table. Reset dictionary is all zero, so columns read as 0.
        add_item_row(8'h00, 1'b1, 1'b1, 8'h00, 1);
        add_item_row(8'hEF, 1'b0, 1'b1, 8'h00, 16);
        add_reg_row(REG_DICT_0_7,   64'hFFFF_FFFF_FFFF_FFFF);
        add_reg_row(REG_DICT_8_15,  64'h8877_6655_4433_2211);
        add_reg_row(REG_DICT_16_23, 64'h0123_4567_89AB_CDEF);
        add_reg_row(REG_DICT_24_30, 64'h00A5_EEDD_CCBB_AA99);
        add_item_row(8'h05, 1'b0, 1'b1, 8'hFF, 6);
        add_item_row(8'hE0, 1'b0, 1'b0, 8'h00, 0);
        // Shortest raw run, then the longest one cut short by a new glyph
        add_item_row(8'hF8, 1'b0, 1'b1, 8'h00, 0);
        add_item_row(8'hA5, 1'b0, 1'b1, 8'hA5, 1);
        add_item_row(8'hFF, 1'b0, 1'b1, 8'h00, 0);
        add_item_row(8'h00, 1'b0, 1'b1, 8'h00, 1);
        add_item_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1);
        add_item_row(8'h13, 1'b1, 1'b0, 8'h00, 0);
        // Shortest and longest repeat
        add_item_row(8'hF0, 1'b0, 1'b1, 8'h00, 0);
        add_item_row(8'hFF, 1'b0, 1'b1, 8'hFF, 2);
        add_item_row(8'hF7, 1'b0, 1'b1, 8'h00, 0);
        add_item_row(8'h3C, 1'b0, 1'b1, 8'h3C, 9);
        // Wide dictionary: first and last entries, then a raw byte
        add_reg_row(REG_DICT_MODE, 64'd1);
        add_item_row(8'h00, 1'b0, 1'b0, 8'h00, 0);
        add_item_row(8'hF7, 1'b0, 1'b0, 8'h00, 0);
        add_item_row(8'hF0, 1'b0, 1'b0, 8'h00, 0);
        add_item_row(8'hF8, 1'b0, 1'b1, 8'h00, 0);
        add_item_row(8'hF0, 1'b0, 1'b1, 8'hF0, 1);
        // Mode flipped while a raw run and then a repeat are pending
        add_item_row(8'hF9, 1'b0, 1'b1, 8'h00, 0);
        add_reg_row(REG_DICT_MODE, 64'd0);
        add_item_row(8'h12, 1'b0, 1'b1, 8'h12, 1);
        add_item_row(8'h34, 1'b0, 1'b1, 8'h34, 1);
        add_item_row(8'hF3, 1'b0, 1'b1, 8'h00, 0);
        add_reg_row(REG_DICT_MODE, 64'd1);
        add_item_row(8'hEE, 1'b0, 1'b1, 8'hEE, 5);
        add_item_row(8'hF5, 1'b1, 1'b0, 8'h00, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
            begin
                wait_idle();
                write_reg(row.reg_index, row.reg_value);
            end
            else
            begin
                // Typed rows still advance the model, but their columns come
                // from the table
                send_code(row.code_byte, row.new_glyph, !row.typed);
                if (row.typed)
                    add_columns(row.typed_value, row.typed_count, 1'b1);
            end
        end

        // Random phases: all-zero and all-ones dictionaries first, then random
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            write_reg(REG_DICT_MODE, (p == 0) ? 64'd0 :
                                     (p == 1) ? 64'd1 : 64'($urandom_range(0, 1)));
            for (int r = 0; r < 4; r++)
            begin
                if (p == 0)
                    word = '0;
                else if (p == 1)
                    word = '1;
                else
                    word = {32'($urandom), 32'($urandom)};
                if (dict_regs[r] == REG_DICT_24_30)
                    word = word & DICT_24_30_MASK;
                write_reg(dict_regs[r], word);
            end
            run_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d compressed bytes into %0d checked columns", byte_count,
                 column_count);
        $display("over %0d register writes, both dictionary modes, in %0d cycles",
                 reg_writes, cycle_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

### font_glyph_run_length_decoder_unit.f
hw/rtl/fgrld_pkg.sv
hw/rtl/fgrld_code_if.sv
hw/rtl/fgrld_pixel_if.sv
hw/rtl/fgrld_front.sv
hw/rtl/fgrld_queue.sv
hw/rtl/fgrld_back.sv
hw/rtl/font_glyph_run_length_decoder_unit.sv
bench/tb_font_glyph_run_length_decoder_unit.sv
